[rtl/qalt_pkg.sv]
// Shared definitions for the quote-aware line tokeniser.
// Character codes, error codes and the result record type.
// No dependencies.
package qalt_pkg;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_BSLASH = 8'd92;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_QUOTE_OPEN = 2'd1;
    localparam logic [1:0] ERR_ESCAPE_EOL = 2'd2;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       token_end;
        logic       line_end;
        logic [1:0] error_code;
    } qalt_result_t;

endpackage

[rtl/qalt_step.sv]
// Tokeniser step: holds the three mode flags and works out one result per byte.
// Depends on qalt_pkg.
module qalt_step (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_fire,
    input  logic [7:0]            byte_in,
    output qalt_pkg::qalt_result_t result
);
    import qalt_pkg::*;

    logic in_token_reg, in_token_next;
    logic in_quotes_reg, in_quotes_next;
    logic escape_reg, escape_next;
    logic is_line_end;
    logic is_sep;

    assign is_line_end = (byte_in == CH_NUL) || (byte_in == CH_LF) || (byte_in == CH_CR);
    assign is_sep      = (byte_in == CH_SPACE) || (byte_in == CH_TAB);

    always_comb begin
        result         = '0;
        in_token_next  = in_token_reg;
        in_quotes_next = in_quotes_reg;
        escape_next    = escape_reg;
        if (is_line_end) begin
            result.line_end = 1'b1;
            if (escape_reg) begin
                result.error_code = ERR_ESCAPE_EOL;
            end else if (in_quotes_reg) begin
                result.error_code = ERR_QUOTE_OPEN;
            end else begin
                result.token_end = in_token_reg;
            end
            in_token_next  = 1'b0;
            in_quotes_next = 1'b0;
            escape_next    = 1'b0;
        end else if (escape_reg) begin
            result.char_valid = 1'b1;
            result.char_out   = byte_in;
            escape_next       = 1'b0;
            in_token_next     = 1'b1;
        end else if (byte_in == CH_QUOTE) begin
            // A quote opens a token even if nothing follows it.
            in_quotes_next = ~in_quotes_reg;
            in_token_next  = 1'b1;
        end else if (byte_in == CH_BSLASH) begin
            escape_next   = 1'b1;
            in_token_next = 1'b1;
        end else if (is_sep && !in_quotes_reg) begin
            result.token_end = in_token_reg;
            in_token_next    = 1'b0;
        end else begin
            result.char_valid = 1'b1;
            result.char_out   = byte_in;
            in_token_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_token_reg  <= 1'b0;
            in_quotes_reg <= 1'b0;
            escape_reg    <= 1'b0;
        end else if (step_fire) begin
            in_token_reg  <= in_token_next;
            in_quotes_reg <= in_quotes_next;
            escape_reg    <= escape_next;
        end
    end

`ifndef ASSERT_OFF
    a_err_needs_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.error_code != ERR_NONE) |-> result.line_end)
        else $error("error code without line end");
    a_eol_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && is_line_end) |=> (!in_token_reg && !in_quotes_reg && !escape_reg))
        else $error("mode flags not cleared after line end");
    a_escape_sets_token: assert property (@(posedge aclk) disable iff (!aresetn)
        escape_reg |-> in_token_reg)
        else $error("escape pending outside a token");
    a_no_char_and_end: assert property (@(posedge aclk) disable iff (!aresetn)
        !(result.char_valid && result.token_end))
        else $error("token byte and token end in one result");
`endif

endmodule

[rtl/quote_aware_line_tokenizer.sv]
// Top level of the quote-aware line tokeniser: input register, step logic and
// result register with valid/ready handshakes. Depends on qalt_pkg and qalt_step.
//
// Usage:
//   The s_ channel carries one byte of a text line per transfer. The m_ channel
//   returns exactly one result per input byte: an optional token byte, a token
//   end mark, a line end mark and an error code.
//   Space and tab split tokens outside double quotes; quotes toggle quoted mode
//   and are dropped; a backslash makes the next byte literal. NUL, LF and CR end
//   the line and clear the mode flags.
//   Path: an accepted byte is held in the input register, then stepped into the
//   result register, which drives m_valid, as soon as that register is free.
//   Throughput: one byte per cycle, limited only by the receiver.
//   The mode flags are updated as a byte moves from the input register to the
//   result register, so each byte sees the flags left by the previous one.
//   Stall: when m_ready is low the result register holds; an empty input register
//   still takes one more byte, after which s_ready falls until the stall clears.
//   Reset (aresetn low, synchronous) empties both registers and clears all flags.
module quote_aware_line_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_char_valid,
    output logic [7:0] m_char_out,
    output logic       m_token_end,
    output logic       m_line_end,
    output logic [1:0] m_error_code
);
    import qalt_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    qalt_result_t out_result_reg;
    qalt_result_t step_result;
    logic         out_free;
    logic         step_fire;

    assign out_free  = !out_valid_reg || m_ready;
    assign step_fire = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    qalt_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_fire (step_fire),
        .byte_in   (in_byte_reg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
        end
        if (step_fire) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_char_valid = out_result_reg.char_valid;
    assign m_char_out   = out_result_reg.char_out;
    assign m_token_end  = out_result_reg.token_end;
    assign m_line_end   = out_result_reg.line_end;
    assign m_error_code = out_result_reg.error_code;

`ifndef ASSERT_OFF
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_result_reg)))
        else $error("result changed while stalled");
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted with both registers full");
    a_step_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> m_valid)
        else $error("stepped byte did not reach the result register");
`endif

endmodule
